>>> hdl/dab_pkg.sv
// ----------------------------------------------------------------------------
// dab_pkg
// Types, constants and the month length table for the date advance unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dab_pkg;

  localparam int unsigned DayBits   = 5;
  localparam int unsigned MonthBits = 4;
  localparam int unsigned CycleBits = 9;

  localparam logic [CycleBits-1:0] YearCycle    = 9'd400;
  localparam logic [CycleBits-1:0] YearCycleTop = 9'd399;
  localparam logic [CycleBits-1:0] Century1     = 9'd100;
  localparam logic [CycleBits-1:0] Century2     = 9'd200;
  localparam logic [CycleBits-1:0] Century3     = 9'd300;

  // The year divided by 400 is the year shifted right by four and then divided
  // by 25 through a reciprocal multiplication, which is exact for 28-bit values.
  localparam int unsigned YearExtBits = 32;
  localparam int unsigned QuoShift    = 4;
  localparam int unsigned RecipBits   = 29;
  localparam int unsigned RecipShift  = 33;
  localparam int unsigned ProdBits    = YearExtBits - QuoShift + RecipBits;
  localparam int unsigned QuoBits     = ProdBits - RecipShift;
  localparam logic [RecipBits-1:0] Div25Recip = 29'd343597384;

  localparam logic [MonthBits-1:0] MonthJan = 4'd1;
  localparam logic [MonthBits-1:0] MonthFeb = 4'd2;
  localparam logic [MonthBits-1:0] MonthMar = 4'd3;
  localparam logic [MonthBits-1:0] MonthMay = 4'd5;
  localparam logic [MonthBits-1:0] MonthJul = 4'd7;
  localparam logic [MonthBits-1:0] MonthAug = 4'd8;
  localparam logic [MonthBits-1:0] MonthOct = 4'd10;
  localparam logic [MonthBits-1:0] MonthDec = 4'd12;

  localparam logic [DayBits-1:0] DaysLong  = 5'd31;
  localparam logic [DayBits-1:0] DaysShort = 5'd30;
  localparam logic [DayBits-1:0] DaysLeap  = 5'd29;
  localparam logic [DayBits-1:0] DaysFeb   = 5'd28;
  localparam logic [DayBits-1:0] DayFirst  = 5'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_STEP,
    ST_DONE
  } dab_state_e;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic step;
    logic emit;
  } dab_cmd_t;

  typedef struct packed {
    logic rem_zero;
    logic out_free;
  } dab_sts_t;

  function automatic logic [DayBits-1:0] month_len(input logic [MonthBits-1:0] m,
                                                   input logic leap);
    logic [DayBits-1:0] len;
    len = DaysShort;
    if (m == MonthJan || m == MonthMar || m == MonthMay || m == MonthJul ||
        m == MonthAug || m == MonthOct || m == MonthDec) begin
      len = DaysLong;
    end else if (m == MonthFeb) begin
      len = leap ? DaysLeap : DaysFeb;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

>>> hdl/dab_in_if.sv
// ----------------------------------------------------------------------------
// dab_in_if
// Input channel of the date advance unit: a start date and a day count.
// ----------------------------------------------------------------------------
`default_nettype none

interface dab_in_if #(
  parameter int unsigned YEAR_BITS  = 16,
  parameter int unsigned DELTA_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [4:0]            start_day;
  logic [3:0]            start_month;
  logic [YEAR_BITS-1:0]  start_year;
  logic [DELTA_BITS-1:0] delta_days;

  modport source (output valid, start_day, start_month, start_year, delta_days,
                  input ready);
  modport sink   (input valid, start_day, start_month, start_year, delta_days,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/dab_out_if.sv
// ----------------------------------------------------------------------------
// dab_out_if
// Output channel of the date advance unit: the resulting date and a wrap flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface dab_out_if #(
  parameter int unsigned YEAR_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [4:0]           day;
  logic [3:0]           month;
  logic [YEAR_BITS-1:0] year;
  logic                 year_overflow;

  modport source (output valid, day, month, year, year_overflow, input ready);
  modport sink   (input valid, day, month, year, year_overflow, output ready);
endinterface

`default_nettype wire

>>> hdl/dab_ctrl.sv
// ----------------------------------------------------------------------------
// dab_ctrl
// Sequencer: loads a word, runs the year remainder, steps the date, emits.
// ----------------------------------------------------------------------------
`default_nettype none

module dab_ctrl
  import dab_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire dab_sts_t sts_i,
  output dab_cmd_t      cmd_o
);

  dab_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_MOD;
      end
      ST_MOD: begin
        state_d = ST_STEP;
      end
      ST_STEP: begin
        if (sts_i.rem_zero) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
      end
      ST_STEP: begin
        cmd_o.step = !sts_i.rem_zero;
      end
      ST_DONE: begin
        cmd_o.emit = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_emit_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free)
    else $error("result emitted while output register is occupied");

  a_done_after_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP && sts_i.rem_zero) |=> state_q == ST_DONE)
    else $error("stepping did not finish when the count ran out");

  a_one_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.mod_step, cmd_o.step, cmd_o.emit}))
    else $error("more than one datapath command at once");

endmodule

`default_nettype wire

>>> hdl/dab_dp.sv
// ----------------------------------------------------------------------------
// dab_dp
// Datapath: date registers, year remainder modulo 400 and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dab_dp
  import dab_pkg::*;
#(
  parameter int unsigned YEAR_BITS  = 16,
  parameter int unsigned DELTA_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire dab_cmd_t              cmd_i,
  output dab_sts_t                   sts_o,
  input  wire logic [DayBits-1:0]    start_day_i,
  input  wire logic [MonthBits-1:0]  start_month_i,
  input  wire logic [YEAR_BITS-1:0]  start_year_i,
  input  wire logic [DELTA_BITS-1:0] delta_days_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [DayBits-1:0]         day_o,
  output logic [MonthBits-1:0]       month_o,
  output logic [YEAR_BITS-1:0]       year_o,
  output logic                       year_overflow_o
);

  localparam logic [YEAR_BITS-1:0] YearTop = '1;

  logic [DayBits-1:0]    d_q, d_d;
  logic [MonthBits-1:0]  m_q, m_d;
  logic [YEAR_BITS-1:0]  y_q, y_d;
  logic [QuoBits-1:0]    quo_q, quo_d;
  logic [DELTA_BITS-1:0] rem_q, rem_d;
  logic [CycleBits-1:0]  r400_q, r400_d;
  logic                  ovf_q, ovf_d;
  logic                  out_valid_q;

  logic                  leap;
  logic [DayBits-1:0]    dim;
  logic [DayBits-1:0]    gap;
  logic [YearExtBits-1:0] yin_ext;
  logic [ProdBits-1:0]   quo_prod;
  logic [QuoBits-1:0]    quo_in;

  assign leap = (r400_q == '0) ||
                (r400_q[1:0] == 2'b00 && r400_q != Century1 &&
                 r400_q != Century2 && r400_q != Century3);
  assign dim      = month_len(m_q, leap);
  assign gap      = dim - d_q;
  assign yin_ext  = YearExtBits'(start_year_i);
  assign quo_prod = ProdBits'(yin_ext[YearExtBits-1:QuoShift]) * ProdBits'(Div25Recip);
  assign quo_in   = quo_prod[ProdBits-1:RecipShift];

  always_comb begin
    d_d    = d_q;
    m_d    = m_q;
    y_d    = y_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    r400_d = r400_q;
    ovf_d  = ovf_q;
    if (cmd_i.load) begin
      d_d    = start_day_i;
      m_d    = start_month_i;
      y_d    = start_year_i;
      quo_d  = quo_in;
      rem_d  = delta_days_i;
      r400_d = '0;
      ovf_d  = 1'b0;
    end else if (cmd_i.mod_step) begin
      r400_d = y_q[CycleBits-1:0] - CycleBits'(quo_q[CycleBits-1:0] * YearCycle);
    end else if (cmd_i.step) begin
      if (d_q >= dim) begin
        d_d   = DayFirst;
        rem_d = rem_q - 1'b1;
        if (m_q == MonthDec) begin
          m_d = MonthJan;
          if (y_q == YearTop) begin
            y_d    = '0;
            r400_d = '0;
            ovf_d  = 1'b1;
          end else begin
            y_d    = y_q + 1'b1;
            r400_d = (r400_q == YearCycleTop) ? '0 : r400_q + 1'b1;
          end
        end else begin
          m_d = m_q + 1'b1;
        end
      end else if (rem_q < DELTA_BITS'(gap)) begin
        d_d   = d_q + rem_q[DayBits-1:0];
        rem_d = '0;
      end else begin
        d_d   = dim;
        rem_d = rem_q - DELTA_BITS'(gap);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    d_q    <= d_d;
    m_q    <= m_d;
    y_q    <= y_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    r400_q <= r400_d;
    ovf_q  <= ovf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      day_o           <= d_q;
      month_o         <= m_q;
      year_o          <= y_q;
      year_overflow_o <= ovf_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.rem_zero = (rem_q == '0);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  a_r400_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> r400_q < YearCycle)
    else $error("year remainder out of range while stepping");

  a_emit_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_valid_q)
    else $error("emitted word not marked valid");

  a_load_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> (!ovf_q && r400_q == '0))
    else $error("overflow flag or remainder not cleared on load");

endmodule

`default_nettype wire

>>> hdl/date_advance_by_days_unit.sv
// ----------------------------------------------------------------------------
// date_advance_by_days_unit
// Adds a day count to a Gregorian date and returns the resulting date.
// ----------------------------------------------------------------------------
// One word is processed at a time. On acceptance a reciprocal multiplication
// divides the start year by 400, and the cycle after it forms the year modulo
// 400, which then tracks leap years as the year advances. The unit then steps
// the date: for each month passed through, one step reaches the month's end
// and one rolls over into the next month. Once the count has run out, the unit
// loads the output register as soon as it is free. A finished result waits in
// that register while the next word is accepted. The year wraps to zero past
// its top value and sets the overflow flag. YEAR_BITS may be at most 32.
`default_nettype none

module date_advance_by_days_unit
  import dab_pkg::*;
#(
  parameter int unsigned YEAR_BITS  = 16,
  parameter int unsigned DELTA_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dab_in_if.sink    in_i,
  dab_out_if.source out_o
);

  dab_cmd_t cmd;
  dab_sts_t sts;

  dab_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dab_dp #(
    .YEAR_BITS  (YEAR_BITS),
    .DELTA_BITS (DELTA_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .start_day_i     (in_i.start_day),
    .start_month_i   (in_i.start_month),
    .start_year_i    (in_i.start_year),
    .delta_days_i    (in_i.delta_days),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .day_o           (out_o.day),
    .month_o         (out_o.month),
    .year_o          (out_o.year),
    .year_overflow_o (out_o.year_overflow)
  );

endmodule

`default_nettype wire
